// ----- src/bfc_pkg.sv -----
package bfc_pkg;

    // Store geometry.
    localparam int DEPTH       = 64;
    localparam int MAX_RESULTS = 64;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int SUM_W       = CNT_W + 1;

    // Field widths of the stream items.
    localparam int CMD_W    = 4;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 7;
    localparam int OFFSET_W = 8;
    localparam int STATUS_W = 3;
    localparam int SIZE_W   = 7;

    // Common width for comparing a requested count against a fill level.
    localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W + 1 : COUNT_W + 1;
    // Signed width that holds a cursor plus a relative move without overflow.
    localparam int SEEK_W = ((CNT_W > OFFSET_W) ? CNT_W : OFFSET_W) + 2;

    // Job queue between the command front end and the result back end.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
    localparam int RUNS_W  = $clog2(Q_DEPTH + 2);

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_cmd CMD_WRITE     = 4'd0;
    localparam t_cmd CMD_READ      = 4'd1;
    localparam t_cmd CMD_EXTRACT   = 4'd2;
    localparam t_cmd CMD_SEEK_ABS  = 4'd3;
    localparam t_cmd CMD_SEEK_REL  = 4'd4;
    localparam t_cmd CMD_CLEAN     = 4'd5;
    localparam t_cmd CMD_CLEAR     = 4'd6;
    localparam t_cmd CMD_CLOSE     = 4'd7;
    localparam t_cmd CMD_SET_ERROR = 4'd8;

    localparam t_status ST_OK      = 3'd0;
    localparam t_status ST_DENIED  = 3'd1;
    localparam t_status ST_NO_DATA = 3'd2;
    localparam t_status ST_SHORT   = 3'd3;
    localparam t_status ST_FULL    = 3'd4;

    // One queued job: either a single status result or a run of stored bytes.
    typedef struct packed {
        logic              is_run;
        logic [IDX_W-1:0]  start;
        logic [CNT_W-1:0]  len;
        t_status           status;
        logic [SIZE_W-1:0] size;
        logic [SIZE_W-1:0] avail;
        logic              eof;
    } t_job;

    // Store write port driven by the front end.
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [BYTE_W-1:0] data;
    } t_wr;

    // Circular index advance; base and step are both at most DEPTH, so a
    // single conditional subtract wraps the sum.
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] step);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(step);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// ----- src/bfc_front.sv -----
module bfc_front import bfc_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  t_cmd                       i_cmd,
    input  logic [BYTE_W-1:0]          i_data_byte,
    input  logic [COUNT_W-1:0]         i_count,
    input  logic signed [OFFSET_W-1:0] i_offset,
    input  logic                       i_q_full,
    input  logic                       i_run_done,
    output logic                       o_push,
    output t_job                       o_job,
    output t_wr                        o_wr
);

    logic [IDX_W-1:0]  r_head,   n_head;
    logic [CNT_W-1:0]  r_fill,   n_fill;
    logic [CNT_W-1:0]  r_cursor, n_cursor;
    logic              r_closed, n_closed;
    logic              r_err,    n_err;
    logic [RUNS_W-1:0] r_runs,   n_runs;

    logic              accept;
    logic [CNT_W-1:0]  avail;
    logic [CNT_W-1:0]  take;
    logic [CNT_W-1:0]  seek_base;
    logic [SEEK_W-1:0] seek_sum;
    t_job              job;

    // Writes wait while any queued or active run may still read the store,
    // since an append can land on a slot that an extract just released.
    assign o_ready = !i_q_full && !(i_cmd == CMD_WRITE && r_runs != '0);
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_head   = r_head;
        n_fill   = r_fill;
        n_cursor = r_cursor;
        n_closed = r_closed;
        n_err    = r_err;
        o_wr     = '0;
        job      = '0;
        job.status = ST_OK;
        job.start  = r_head;

        avail = (i_cmd == CMD_READ) ? r_fill - r_cursor : r_fill;
        if (i_count == '0 || CMP_W'(i_count) > CMP_W'(avail)) begin
            take = avail;
        end else begin
            take = CNT_W'(i_count);
        end
        if (CMP_W'(take) > CMP_W'(MAX_RESULTS)) begin
            take = CNT_W'(MAX_RESULTS);
        end

        seek_base = (i_cmd == CMD_SEEK_REL) ? r_cursor : '0;
        seek_sum  = SEEK_W'(seek_base) + SEEK_W'(i_offset);

        case (i_cmd)
            CMD_WRITE: begin
                if (r_closed || r_err) begin
                    job.status = ST_DENIED;
                end else if (r_fill == CNT_W'(DEPTH)) begin
                    job.status = ST_FULL;
                end else begin
                    o_wr.en   = accept;
                    o_wr.addr = wrap_add(r_head, r_fill);
                    o_wr.data = i_data_byte;
                    n_fill    = r_fill + CNT_W'(1);
                end
            end
            CMD_READ, CMD_EXTRACT: begin
                if (r_err) begin
                    job.status = ST_DENIED;
                end else if (i_count != '0 && avail == '0) begin
                    job.status = ST_NO_DATA;
                end else if (r_closed && CMP_W'(i_count) > CMP_W'(avail)) begin
                    job.status = ST_SHORT;
                end else if (take != '0) begin
                    job.is_run = 1'b1;
                    job.len    = take;
                    if (i_cmd == CMD_READ) begin
                        job.start = wrap_add(r_head, r_cursor);
                        n_cursor  = r_cursor + take;
                    end else begin
                        n_head   = wrap_add(r_head, take);
                        n_fill   = r_fill - take;
                        n_cursor = (r_cursor > take) ? r_cursor - take : '0;
                    end
                end
            end
            CMD_SEEK_ABS, CMD_SEEK_REL: begin
                if (seek_sum[SEEK_W-1]) begin
                    n_cursor = '0;
                end else if (seek_sum > SEEK_W'(r_fill)) begin
                    n_cursor = r_fill;
                end else begin
                    n_cursor = CNT_W'(seek_sum);
                end
            end
            CMD_CLEAN: begin
                if (r_cursor != '0) begin
                    n_head   = wrap_add(r_head, r_cursor);
                    n_fill   = r_fill - r_cursor;
                    n_cursor = '0;
                end
            end
            CMD_CLEAR: begin
                n_head   = '0;
                n_fill   = '0;
                n_cursor = '0;
            end
            CMD_CLOSE: begin
                n_closed = 1'b1;
            end
            CMD_SET_ERROR: begin
                n_err = 1'b1;
            end
            default: begin
            end
        endcase

        // Every result reports the state as it stands after the command.
        job.size  = SIZE_W'(n_fill);
        job.avail = SIZE_W'(n_fill - n_cursor);
        job.eof   = n_err || (n_closed && n_fill == n_cursor);

        n_runs = r_runs + RUNS_W'(accept && job.is_run) - RUNS_W'(i_run_done);
    end

    assign o_push = accept;
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_fill   <= '0;
            r_cursor <= '0;
            r_closed <= 1'b0;
            r_err    <= 1'b0;
            r_runs   <= '0;
        end else begin
            r_runs <= n_runs;
            if (accept) begin
                r_head   <= n_head;
                r_fill   <= n_fill;
                r_cursor <= n_cursor;
                r_closed <= n_closed;
                r_err    <= n_err;
            end
        end
    end

endmodule

// ----- src/bfc_queue.sv -----
module bfc_queue import bfc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    t_job               r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wp + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rp + Q_PTR_W'(1);
            end
            r_cnt <= r_cnt + Q_CNT_W'(i_push) - Q_CNT_W'(i_pop);
        end
    end

endmodule

// ----- src/bfc_back.sv -----
module bfc_back import bfc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_job                i_job,
    input  logic                i_q_empty,
    output logic                o_pop,
    input  t_wr                 i_wr,
    output logic                o_run_done,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [BYTE_W-1:0]   o_out_byte,
    output logic                o_has_byte,
    output logic                o_last,
    output t_status             o_status,
    output logic [SIZE_W-1:0]   o_size_now,
    output logic [SIZE_W-1:0]   o_available_now,
    output logic                o_end_of_file
);

    logic [BYTE_W-1:0] r_mem [DEPTH];

    // Run in progress.
    logic              r_busy, n_busy;
    logic [IDX_W-1:0]  r_addr, n_addr;
    logic [CNT_W-1:0]  r_left, n_left;
    t_job              r_cur,  n_cur;

    // Read stage, holding the registered store data.
    logic              r_s1_v;
    logic              r_s1_has;
    logic              r_s1_last;
    t_job              r_s1_meta;
    logic [BYTE_W-1:0] r_s1_byte;

    // Output register.
    logic              r_o_v;
    logic [BYTE_W-1:0] r_o_byte;
    logic              r_o_has;
    logic              r_o_last;
    t_job              r_o_meta;

    logic              out_free;
    logic              s1_free;
    logic              iss;
    logic              iss_has;
    logic              iss_last;
    logic [IDX_W-1:0]  iss_addr;
    t_job              iss_meta;

    assign out_free = !r_o_v || i_ready;
    assign s1_free  = !r_s1_v || out_free;

    always_comb begin
        iss        = 1'b0;
        iss_has    = 1'b0;
        iss_last   = 1'b1;
        iss_addr   = r_addr;
        iss_meta   = r_cur;
        o_pop      = 1'b0;
        o_run_done = 1'b0;
        n_busy     = r_busy;
        n_addr     = r_addr;
        n_left     = r_left;
        n_cur      = r_cur;
        if (s1_free) begin
            if (r_busy) begin
                iss      = 1'b1;
                iss_has  = 1'b1;
                iss_last = (r_left == CNT_W'(1));
                n_addr   = wrap_add(r_addr, CNT_W'(1));
                n_left   = r_left - CNT_W'(1);
                if (iss_last) begin
                    n_busy     = 1'b0;
                    o_run_done = 1'b1;
                end
            end else if (!i_q_empty) begin
                o_pop    = 1'b1;
                iss      = 1'b1;
                iss_meta = i_job;
                if (i_job.is_run) begin
                    iss_has  = 1'b1;
                    iss_addr = i_job.start;
                    iss_last = (i_job.len == CNT_W'(1));
                    if (iss_last) begin
                        o_run_done = 1'b1;
                    end else begin
                        n_busy = 1'b1;
                        n_addr = wrap_add(i_job.start, CNT_W'(1));
                        n_left = i_job.len - CNT_W'(1);
                        n_cur  = i_job;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (iss && iss_has) begin
            r_s1_byte <= r_mem[iss_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_left <= n_left;
        r_cur  <= n_cur;
        if (s1_free && iss) begin
            r_s1_has  <= iss_has;
            r_s1_last <= iss_last;
            r_s1_meta <= iss_meta;
        end
        if (out_free && r_s1_v) begin
            r_o_byte <= r_s1_has ? r_s1_byte : '0;
            r_o_has  <= r_s1_has;
            r_o_last <= r_s1_last;
            r_o_meta <= r_s1_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_s1_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (s1_free) begin
                r_s1_v <= iss;
            end
            if (out_free) begin
                r_o_v <= r_s1_v;
            end
        end
    end

    assign o_valid         = r_o_v;
    assign o_out_byte      = r_o_byte;
    assign o_has_byte      = r_o_has;
    assign o_last          = r_o_last;
    assign o_status        = r_o_meta.status;
    assign o_size_now      = r_o_meta.size;
    assign o_available_now = r_o_meta.avail;
    assign o_end_of_file   = r_o_meta.eof;

endmodule

// ----- src/byte_fifo_with_read_cursor.sv -----
// Throughput: one command per cycle while the job queue has room; a read or extract run
// delivers one byte per cycle while the output is ready, set by the single store read
// port and the read stage in the result back end.
// A write waits at the input while any read or extract run is queued or in progress.
// Reset (synchronous, active low) empties the store, clears cursor and flags and drops
// queued jobs; the byte store itself is not cleared and needs no clearing pass.
module byte_fifo_with_read_cursor import bfc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // data_byte [7:0], count [14:8], offset [22:15], zero [23]
    input  logic [23:0] s_axis_tdata,
    // cmd [3:0]
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_byte [7:0], status [10:8], size_now [17:11], available_now [24:18],
    // end_of_file [25], zero [31:26]
    output logic [31:0] m_axis_tdata,
    // has_byte [0]
    output logic [0:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    // The front end decodes each command, updates head, fill level, cursor and
    // flags at once, writes appended bytes into the store, and queues one job
    // per command. The back end turns each job into its result transfers.
    t_job              fr_job;
    t_job              q_job;
    t_wr               wr;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_empty;
    logic              run_done;

    logic [BYTE_W-1:0] out_byte;
    logic              has_byte;
    logic              last;
    t_status           status;
    logic [SIZE_W-1:0] size_now;
    logic [SIZE_W-1:0] available_now;
    logic              end_of_file;

    bfc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_cmd       (s_axis_tuser),
        .i_data_byte (s_axis_tdata[7:0]),
        .i_count     (s_axis_tdata[14:8]),
        .i_offset    ($signed(s_axis_tdata[22:15])),
        .i_q_full    (q_full),
        .i_run_done  (run_done),
        .o_push      (push),
        .o_job       (fr_job),
        .o_wr        (wr)
    );

    // A few jobs of slack let short status results flow while a long run
    // drains at the output.
    bfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (fr_job),
        .i_pop   (pop),
        .o_job   (q_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    bfc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job           (q_job),
        .i_q_empty       (q_empty),
        .o_pop           (pop),
        .i_wr            (wr),
        .o_run_done      (run_done),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_out_byte      (out_byte),
        .o_has_byte      (has_byte),
        .o_last          (last),
        .o_status        (status),
        .o_size_now      (size_now),
        .o_available_now (available_now),
        .o_end_of_file   (end_of_file)
    );

    assign m_axis_tdata = {6'b0, end_of_file, available_now, size_now, status, out_byte};
    assign m_axis_tuser = has_byte;
    assign m_axis_tlast = last;

endmodule
